FILE: hdl/edfs_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// edfs_pkg: shared definitions for the EDF periodic task scheduler
// Widths of the fixed ports, register codes, parameter defaults and the
// sequencer state type.
// ----------------------------------------------------------------------------
package edfs_pkg;

	localparam int MAX_TASKS_DEF   = 4;
	localparam int FIELD_WIDTH_DEF = 16;

	localparam int NUM_PARAM_REGS = 4;
	localparam int PARAM_W        = 48;
	localparam int CFG_IDX_W      = 3;
	localparam int COUNT_W        = 3;
	localparam int TASK_OUT_W     = 3;
	localparam int TIME_W         = 32;
	localparam int BUDGET_OUT_W   = 16;

	// Register indexes of the configuration port.
	localparam int REG_TASK_COUNT = 0;
	localparam int REG_TASK0      = 1;

	// Field slots inside a task parameter register.
	localparam int FLD_CAPACITY = 0;
	localparam int FLD_DEADLINE = 1;
	localparam int FLD_PERIOD   = 2;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_COMMIT
	} sched_state_t;

endpackage
`default_nettype wire

FILE: hdl/edfs_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// edfs_if: handshake channels of the EDF scheduler
// tick_if carries tick requests in, slot_if carries slot results out.
// ----------------------------------------------------------------------------
interface edfs_tick_if;
	logic valid;
	logic ready;
	logic tick;

	modport source (output valid, output tick, input ready);
	modport sink (input valid, input tick, output ready);
endinterface

interface edfs_slot_if;
	logic        valid;
	logic        ready;
	logic [2:0]  running_task;
	logic [31:0] slot_start;
	logic [15:0] budget_before;

	modport source (output valid, output running_task, output slot_start,
		output budget_before, input ready);
	modport sink (input valid, input running_task, input slot_start,
		input budget_before, output ready);
endinterface
`default_nettype wire

FILE: hdl/edf_periodic_task_scheduler_top.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// edf_periodic_task_scheduler_top: earliest-deadline-first slot scheduler
// Each tick request schedules one slot among up to MAX_TASKS periodic tasks
// and returns the running task, the slot time and its budget before the run.
// ----------------------------------------------------------------------------
// Each tick request is accepted in ST_IDLE, visits every task in ST_SCAN
// through the shared release and compare unit, and in ST_COMMIT, once the
// output register is free, charges the chosen task and registers the result.
// The tick input is not ready again until that commit is done; a finished
// result waits in the output register while the next tick is taken. A request
// whose tick bit is zero is taken and dropped with no result. The user must
// write configuration via cfg_wen/cfg_index/cfg_wdata while idle; not enforced.
module edf_periodic_task_scheduler_top #(
	parameter int MAX_TASKS   = edfs_pkg::MAX_TASKS_DEF,
	parameter int FIELD_WIDTH = edfs_pkg::FIELD_WIDTH_DEF
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	edfs_tick_if.sink                           ticks,
	edfs_slot_if.source                         slots,
	input  wire logic                           cfg_wen,
	input  wire logic [edfs_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [edfs_pkg::PARAM_W-1:0]   cfg_wdata
);
	import edfs_pkg::*;

	localparam int IDX_W = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;

	sched_state_t state_q, state_nxt;

	logic [COUNT_W-1:0] task_count;
	logic [PARAM_W-1:0] task_params [NUM_PARAM_REGS];
	logic [PARAM_W-1:0] sel_params;

	logic [FIELD_WIDTH-1:0]        phase_q  [MAX_TASKS];
	logic [FIELD_WIDTH-1:0]        budget_q [MAX_TASKS];
	logic signed [FIELD_WIDTH:0]   slack_q  [MAX_TASKS];

	logic [IDX_W-1:0]             idx_q;
	logic                         best_valid_q;
	logic [IDX_W-1:0]             best_idx_q;
	logic signed [FIELD_WIDTH:0]  best_slack_q;
	logic [FIELD_WIDTH-1:0]       best_budget_q;
	logic [TIME_W-1:0]            time_q;

	logic                         out_valid_q;
	logic [TASK_OUT_W-1:0]        out_task_q;
	logic [TIME_W-1:0]            out_start_q;
	logic [BUDGET_OUT_W-1:0]      out_budget_q;

	logic [FIELD_WIDTH-1:0]       phase_nxt;
	logic [FIELD_WIDTH-1:0]       budget_nxt;
	logic signed [FIELD_WIDTH:0]  slack_nxt;
	logic signed [FIELD_WIDTH:0]  slack_rel;
	logic                         take;

	logic idx_last;
	logic out_free;
	logic start_en;
	logic scan_en;
	logic commit_en;

	edfs_cfg_regs u_cfg (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wen     (cfg_wen),
		.cfg_index   (cfg_index),
		.cfg_wdata   (cfg_wdata),
		.task_count  (task_count),
		.task_params (task_params)
	);

	// Tasks beyond the parameter registers have all-zero parameters.
	always_comb begin
		sel_params = '0;
		for (int j = 0; j < NUM_PARAM_REGS; j++) begin
			if (int'(idx_q) == j) begin
				sel_params = task_params[j];
			end
		end
	end

	edfs_task_unit #(
		.FIELD_WIDTH (FIELD_WIDTH),
		.IDX_W       (IDX_W)
	) u_unit (
		.idx        (idx_q),
		.task_count (task_count),
		.params     (sel_params),
		.phase      (phase_q[idx_q]),
		.budget     (budget_q[idx_q]),
		.slack      (slack_q[idx_q]),
		.best_valid (best_valid_q),
		.best_slack (best_slack_q),
		.phase_nxt  (phase_nxt),
		.budget_nxt (budget_nxt),
		.slack_nxt  (slack_nxt),
		.slack_rel  (slack_rel),
		.take       (take)
	);

	assign idx_last = (idx_q == IDX_W'(MAX_TASKS - 1));
	assign out_free = !out_valid_q || slots.ready;

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_IDLE: begin
				if (ticks.valid && ticks.tick) begin
					state_nxt = ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (idx_last) begin
					state_nxt = ST_COMMIT;
				end
			end
			ST_COMMIT: begin
				if (out_free) begin
					state_nxt = ST_IDLE;
				end
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	always_comb begin
		ticks.ready = 1'b0;
		start_en    = 1'b0;
		scan_en     = 1'b0;
		commit_en   = 1'b0;
		case (state_q)
			ST_IDLE: begin
				ticks.ready = 1'b1;
				start_en    = ticks.valid && ticks.tick;
			end
			ST_SCAN:   scan_en = 1'b1;
			ST_COMMIT: commit_en = out_free;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q        <= '0;
			best_valid_q <= 1'b0;
			time_q       <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			if (start_en) begin
				idx_q        <= '0;
				best_valid_q <= 1'b0;
			end else if (scan_en) begin
				idx_q <= idx_q + IDX_W'(1);
				if (take) begin
					best_valid_q <= 1'b1;
				end
			end
			if (commit_en) begin
				time_q      <= time_q + TIME_W'(1);
				out_valid_q <= 1'b1;
			end else if (slots.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (scan_en && take) begin
			best_idx_q    <= idx_q;
			best_slack_q  <= slack_rel;
			best_budget_q <= budget_nxt;
		end
		if (commit_en) begin
			out_start_q <= time_q;
			if (best_valid_q) begin
				out_task_q   <= TASK_OUT_W'(int'(best_idx_q) + 1);
				out_budget_q <= BUDGET_OUT_W'(best_budget_q);
			end else begin
				out_task_q   <= '0;
				out_budget_q <= '0;
			end
		end
	end

	// Per-task state: written back by the scan, charged at commit.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int j = 0; j < MAX_TASKS; j++) begin
				phase_q[j]  <= '0;
				budget_q[j] <= '0;
				slack_q[j]  <= '0;
			end
		end else if (scan_en) begin
			phase_q[idx_q]  <= phase_nxt;
			budget_q[idx_q] <= budget_nxt;
			slack_q[idx_q]  <= slack_nxt;
		end else if (commit_en && best_valid_q) begin
			budget_q[best_idx_q] <= best_budget_q - FIELD_WIDTH'(1);
		end
	end

	assign slots.valid         = out_valid_q;
	assign slots.running_task  = out_task_q;
	assign slots.slot_start    = out_start_q;
	assign slots.budget_before = out_budget_q;

endmodule
`default_nettype wire

FILE: hdl/edfs_cfg_regs.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// edfs_cfg_regs: configuration register file
// Holds the task count and the four task parameter words.
// ----------------------------------------------------------------------------
module edfs_cfg_regs (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           cfg_wen,
	input  wire logic [edfs_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [edfs_pkg::PARAM_W-1:0]   cfg_wdata,
	output logic [edfs_pkg::COUNT_W-1:0]        task_count,
	output logic [edfs_pkg::PARAM_W-1:0]        task_params [edfs_pkg::NUM_PARAM_REGS]
);
	import edfs_pkg::*;

	logic [COUNT_W-1:0] task_count_q;
	logic [PARAM_W-1:0] params_q [NUM_PARAM_REGS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			task_count_q <= COUNT_W'(1);
			for (int j = 0; j < NUM_PARAM_REGS; j++) begin
				params_q[j] <= '0;
			end
		end else if (cfg_wen) begin
			if (cfg_index == CFG_IDX_W'(REG_TASK_COUNT)) begin
				task_count_q <= cfg_wdata[COUNT_W-1:0];
			end
			for (int j = 0; j < NUM_PARAM_REGS; j++) begin
				if (cfg_index == CFG_IDX_W'(REG_TASK0 + j)) begin
					params_q[j] <= cfg_wdata;
				end
			end
		end
	end

	assign task_count  = task_count_q;
	assign task_params = params_q;

endmodule
`default_nettype wire

FILE: hdl/edfs_task_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// edfs_task_unit: shared per-task release, compare and advance unit
// Visits one task per cycle: releases it at the start of its period,
// compares its slack against the best so far and computes its next phase,
// budget and slack.
// ----------------------------------------------------------------------------
module edfs_task_unit #(
	parameter int FIELD_WIDTH = edfs_pkg::FIELD_WIDTH_DEF,
	parameter int IDX_W       = 2
) (
	input  wire logic [IDX_W-1:0]               idx,
	input  wire logic [edfs_pkg::COUNT_W-1:0]   task_count,
	input  wire logic [edfs_pkg::PARAM_W-1:0]   params,
	input  wire logic [FIELD_WIDTH-1:0]         phase,
	input  wire logic [FIELD_WIDTH-1:0]         budget,
	input  wire logic signed [FIELD_WIDTH:0]    slack,
	input  wire logic                           best_valid,
	input  wire logic signed [FIELD_WIDTH:0]    best_slack,
	output logic [FIELD_WIDTH-1:0]              phase_nxt,
	output logic [FIELD_WIDTH-1:0]              budget_nxt,
	output logic signed [FIELD_WIDTH:0]         slack_nxt,
	output logic signed [FIELD_WIDTH:0]         slack_rel,
	output logic                                take
);
	import edfs_pkg::*;

	localparam int EXT_W = PARAM_W + 3 * FIELD_WIDTH;
	localparam logic signed [FIELD_WIDTH:0] SLACK_MIN = {1'b1, {FIELD_WIDTH{1'b0}}};

	logic [EXT_W-1:0]       params_ext;
	logic [FIELD_WIDTH-1:0] capacity;
	logic [FIELD_WIDTH-1:0] deadline;
	logic [FIELD_WIDTH-1:0] period;
	logic                   active;
	logic                   release_now;
	logic [FIELD_WIDTH:0]   phase_inc;

	// Fields that lie beyond the parameter word read as zero.
	assign params_ext = EXT_W'(params);
	assign capacity   = params_ext[FLD_CAPACITY * FIELD_WIDTH +: FIELD_WIDTH];
	assign deadline   = params_ext[FLD_DEADLINE * FIELD_WIDTH +: FIELD_WIDTH];
	assign period     = params_ext[FLD_PERIOD * FIELD_WIDTH +: FIELD_WIDTH];

	assign active      = (int'(idx) < int'(task_count)) && (period != '0);
	assign release_now = (phase == '0);
	assign phase_inc   = {1'b0, phase} + (FIELD_WIDTH + 1)'(1);

	always_comb begin
		phase_nxt  = '0;
		budget_nxt = '0;
		slack_nxt  = '0;
		slack_rel  = '0;
		take       = 1'b0;
		if (active) begin
			budget_nxt = release_now ? capacity : budget;
			slack_rel  = release_now ? $signed({1'b0, deadline}) : slack;
			take       = (budget_nxt != '0) && (!best_valid || (slack_rel < best_slack));
			slack_nxt  = (slack_rel != SLACK_MIN) ? slack_rel - (FIELD_WIDTH + 1)'(1)
				: slack_rel;
			// A phase at or past a lowered period wraps at once.
			phase_nxt  = (phase_inc >= {1'b0, period}) ? '0 : phase_inc[FIELD_WIDTH-1:0];
		end
	end

endmodule
`default_nettype wire

FILE: verif/edf_periodic_task_scheduler_top_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// edf_periodic_task_scheduler_top_test: self-checking bench for the EDF scheduler
// Sends tick requests under several task settings and checks every slot result
// against a cycle-free model of release, earliest-deadline choice and charging.
// ----------------------------------------------------------------------------
module edf_periodic_task_scheduler_top_test;
	import edfs_pkg::*;

	localparam int NT = MAX_TASKS_DEF;
	localparam int FW = FIELD_WIDTH_DEF;
	localparam int REG_SPARE = REG_TASK0 + NUM_PARAM_REGS;
	localparam int SETTLE = 12;
	localparam int LONG_HOLD = 300;
	localparam int CYCLE_LIMIT = 200000;
	localparam int PHASES = 8;
	localparam int TICKS_PER_PHASE = 48;

	typedef struct packed {
		logic [TASK_OUT_W-1:0]   running_task;
		logic [TIME_W-1:0]       slot_start;
		logic [BUDGET_OUT_W-1:0] budget_before;
	} slot_t;

	class edf_slot_board;
		logic [COUNT_W-1:0] task_count;
		logic [PARAM_W-1:0] params[NUM_PARAM_REGS];
		logic [TIME_W-1:0]  now;
		logic [FW-1:0]      phase[NT];
		logic [FW-1:0]      budget[NT];
		logic signed [FW:0] slack[NT];
		slot_t              due_slots[$];
		int unsigned        errors, checked, busy, idle, late;

		function new();
			task_count = COUNT_W'(1);
			now = '0;
			for (int i = 0; i < NUM_PARAM_REGS; i++) params[i] = '0;
			for (int i = 0; i < NT; i++) begin
				phase[i] = '0;
				budget[i] = '0;
				slack[i] = '0;
			end
		endfunction

		function logic [FW-1:0] param_field(int k, int slot);
			return params[k][slot*FW +: FW];
		endfunction

		function void write_reg(int idx, logic [PARAM_W-1:0] data);
			if (idx == REG_TASK_COUNT)
				task_count = data[COUNT_W-1:0];
			else if (idx >= REG_TASK0 && idx < REG_TASK0 + NUM_PARAM_REGS)
				params[idx - REG_TASK0] = data;
		endfunction

		// One tick request: release, pick the earliest deadline, charge it, age all.
		function void note_request(logic t);
			logic signed [FW:0] floor_slack;
			logic               act[NT];
			int                 cnt;
			int                 best;
			slot_t              s;
			if (!t)
				return;
			floor_slack = {1'b1, {FW{1'b0}}};
			cnt = (task_count > NT) ? NT : int'(task_count);
			for (int i = 0; i < NT; i++) begin
				act[i] = (i < cnt) && (param_field(i, FLD_PERIOD) != 0);
				if (!act[i]) begin
					phase[i] = '0;
					budget[i] = '0;
					slack[i] = '0;
				end else if (phase[i] == 0) begin
					budget[i] = param_field(i, FLD_CAPACITY);
					slack[i] = $signed({1'b0, param_field(i, FLD_DEADLINE)});
				end
			end
			best = -1;
			for (int i = 0; i < NT; i++) begin
				if (act[i] && budget[i] != 0) begin
					if (best < 0)
						best = i;
					else if (slack[i] < slack[best])
						best = i;
				end
			end
			s.slot_start = now;
			if (best < 0) begin
				s.running_task = '0;
				s.budget_before = '0;
				idle++;
			end else begin
				s.running_task = TASK_OUT_W'(best + 1);
				s.budget_before = budget[best];
				budget[best] = budget[best] - 1'b1;
				busy++;
				if (slack[best] < 0)
					late++;
			end
			for (int i = 0; i < NT; i++) begin
				if (act[i]) begin
					if (slack[i] != floor_slack)
						slack[i] = slack[i] - (FW + 1)'(1);
					if (int'(phase[i]) + 1 >= int'(param_field(i, FLD_PERIOD)))
						phase[i] = '0;
					else
						phase[i] = phase[i] + 1'b1;
				end
			end
			now = now + 1'b1;
			due_slots.insert(due_slots.size(), s);
		endfunction

		function void check_slot(slot_t got);
			slot_t want;
			if (due_slots.size() == 0) begin
				$display("%0t: slot with nothing pending: task %0d start %0d budget %0d",
					$time, got.running_task, got.slot_start, got.budget_before);
				errors++;
				return;
			end
			want = due_slots.pop_front();
			checked++;
			if (got.running_task !== want.running_task) begin
				$display("%0t: running_task expected %0d actual %0d",
					$time, want.running_task, got.running_task);
				errors++;
			end
			if (got.slot_start !== want.slot_start) begin
				$display("%0t: slot_start expected %0d actual %0d",
					$time, want.slot_start, got.slot_start);
				errors++;
			end
			if (got.budget_before !== want.budget_before) begin
				$display("%0t: budget_before expected %0d actual %0d",
					$time, want.budget_before, got.budget_before);
				errors++;
			end
		endfunction

		function int pending();
			return due_slots.size();
		endfunction
	endclass

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_wen;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [PARAM_W-1:0]   cfg_wdata;
	bit                   calm;
	int unsigned          hold_asked;
	int unsigned          hold_done;
	int unsigned          cycles;
	int unsigned          settings;
	edf_slot_board        board;

	edfs_tick_if tick_ch ();
	edfs_slot_if slot_ch ();

	edf_periodic_task_scheduler_top i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.ticks     (tick_ch),
		.slots     (slot_ch),
		.cfg_wen   (cfg_wen),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	always begin
		clk = 1'b0;
		#2;
		clk = 1'b1;
		#2;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	// Results are checked before the request of the same edge is modeled.
	always @(posedge clk) begin
		if (arst_n) begin
			if (slot_ch.valid && slot_ch.ready)
				board.check_slot({slot_ch.running_task, slot_ch.slot_start,
					slot_ch.budget_before});
			if (tick_ch.valid && tick_ch.ready)
				board.note_request(tick_ch.tick);
		end
	end

	// Result side: random back-pressure, plus a long hold whenever one is asked.
	initial begin : slot_drain
		int unsigned held;
		held = 0;
		slot_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_asked != hold_done) begin
				slot_ch.ready <= 1'b0;
				held++;
				if (held == LONG_HOLD) begin
					held = 0;
					hold_done++;
				end
			end else if (calm) begin
				slot_ch.ready <= 1'b1;
			end else begin
				slot_ch.ready <= ($urandom_range(0, 99) >= 30);
			end
		end
	end

	task automatic send_tick(input logic t);
		@(negedge clk);
		if (!calm) begin
			while ($urandom_range(0, 99) < 30) begin
				tick_ch.valid <= 1'b0;
				@(negedge clk);
			end
		end
		tick_ch.valid <= 1'b1;
		tick_ch.tick <= t;
		forever begin
			@(posedge clk);
			if (tick_ch.ready)
				break;
			@(negedge clk);
		end
	endtask

	// Stop sending and let every pending slot come back, then let the block settle.
	task automatic drain();
		@(negedge clk);
		tick_ch.valid <= 1'b0;
		while (board.pending() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_reg(input int idx, input logic [PARAM_W-1:0] data);
		@(negedge clk);
		cfg_wen <= 1'b1;
		cfg_index <= CFG_IDX_W'(idx);
		cfg_wdata <= data;
		board.write_reg(idx, data);
		@(negedge clk);
		cfg_wen <= 1'b0;
	endtask

	function automatic logic [PARAM_W-1:0] pack_task(int per, int dl, int cap);
		return {FW'(per), FW'(dl), FW'(cap)};
	endfunction

	// Mostly short periods so that releases, lateness and ties come often.
	task automatic pick_setting();
		int r;
		int per;
		r = $urandom_range(0, 9);
		if (r == 0)
			write_reg(REG_TASK_COUNT, PARAM_W'($urandom_range(5, 7)));
		else if (r == 1)
			write_reg(REG_TASK_COUNT, PARAM_W'(0));
		else
			write_reg(REG_TASK_COUNT, PARAM_W'($urandom_range(1, 4)));
		for (int k = 0; k < NUM_PARAM_REGS; k++) begin
			r = $urandom_range(0, 9);
			per = $urandom_range(1, 12);
			if (r == 0)
				write_reg(REG_TASK0 + k, {16'($urandom), 32'($urandom)});
			else if (r == 1)
				write_reg(REG_TASK0 + k, pack_task(0, $urandom_range(0, 8),
					$urandom_range(0, 8)));
			else
				write_reg(REG_TASK0 + k, pack_task(per, $urandom_range(0, per + 4),
					$urandom_range(0, per)));
		end
		settings++;
	endtask

	initial begin : stimulus
		board = new();
		arst_n = 1'b0;
		cfg_wen = 1'b0;
		cfg_index = '0;
		cfg_wdata = '0;
		tick_ch.valid = 1'b0;
		tick_ch.tick = 1'b0;
		calm = 1'b0;
		hold_asked = 0;
		hold_done = 0;
		cycles = 0;
		settings = 0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Reset settings: task 0 has period zero, so the slot is idle.
		send_tick(1'b1);
		send_tick(1'b0);
		drain();

		// Task 1 cannot meet its deadline, task 2 has no capacity, task 3 is all ones.
		write_reg(REG_TASK_COUNT, PARAM_W'(4));
		write_reg(REG_TASK0 + 0, pack_task(4, 3, 2));
		write_reg(REG_TASK0 + 1, pack_task(8, 1, 5));
		write_reg(REG_TASK0 + 2, pack_task(3, 3, 0));
		write_reg(REG_TASK0 + 3, '1);
		repeat (8) send_tick(1'b1);
		drain();

		// Count above the maximum, task 0 period lowered, a tie.
		write_reg(REG_TASK_COUNT, PARAM_W'(7));
		write_reg(REG_TASK0 + 0, pack_task(2, 3, 1));
		write_reg(REG_TASK0 + 2, pack_task(4, 3, 1));
		repeat (5) send_tick(1'b1);
		drain();

		// No task takes part at all.
		write_reg(REG_TASK_COUNT, PARAM_W'(0));
		send_tick(1'b1);
		send_tick(1'b1);
		drain();
		write_reg(REG_SPARE, {16'($urandom), 32'($urandom)});
		for (int k = 0; k < NUM_PARAM_REGS; k++)
			write_reg(REG_TASK0 + k, '0);
		settings = 4;

		for (int ph = 0; ph < PHASES; ph++) begin
			drain();
			pick_setting();
			calm = (ph == 3);
			for (int n = 0; n < TICKS_PER_PHASE; n++) begin
				if (ph == 5 && n == 10)
					hold_asked++;
				if (ph == 6 && n == 25)
					drain();
				send_tick($urandom_range(0, 9) != 0);
			end
		end
		calm = 1'b0;
		drain();

		$display("tb: %0d slots checked over %0d task settings", board.checked, settings);
		$display("tb: %0d busy slots, %0d idle slots, %0d run past their deadline",
			board.busy, board.idle, board.late);
		if (board.errors == 0 && board.pending() == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule
